// ===== rtl/lgpl_pkg.sv =====
// ----------------------------------------------------------------------------
// LiDAR ground labeller package
// Shared register codes, reset values, queue sizing, the front-to-back item
// structure and small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lgpl_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SENSOR_HEIGHT   = 2'd0;
    localparam logic [1:0] CFG_MAX_SLOPE_SINE  = 2'd1;
    localparam logic [1:0] CFG_MAX_GROUND_STEP = 2'd2;

    // Register values after reset.
    localparam logic signed [15:0] SENSOR_HEIGHT_RST   = 16'sd200;
    localparam logic [15:0]        MAX_SLOPE_SINE_RST  = 16'd11380;
    localparam logic [14:0]        MAX_GROUND_STEP_RST = 15'd20;

    // Decoupling queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Configuration as seen by the processing modules.
    typedef struct packed {
        logic signed [15:0] sensor_height;
        logic [15:0]        max_slope_sine;
        logic [14:0]        max_ground_step;
    } t_lgpl_cfg;

    // One classified point, handed from the front to the back.
    typedef struct packed {
        logic               hit;        // ground-mode threshold test failed
        logic               lower;      // current z below previous z
        logic signed [15:0] cur_z;
        logic signed [15:0] prev_z;     // previous z after bin-start override
        logic               bin_start;
    } t_lgpl_item;

    // Magnitude of the difference of two signed 16-bit values.
    function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic [16:0] d;
        logic [16:0] n;
        d = {a[15], a} - {b[15], b};
        n = -d;
        return d[16] ? n[15:0] : d[15:0];
    endfunction

    // Square of an unsigned 16-bit magnitude.
    function automatic logic [31:0] square16(input logic [15:0] a);
        return {16'b0, a} * {16'b0, a};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lgpl_front.sv =====
// ----------------------------------------------------------------------------
// LiDAR ground labeller front
// Accepts points, tracks the previous point and runs the slope, range and
// zero-distance tests through a four-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpl_front
    import lgpl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_lgpl_cfg  i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [47:0] i_data,
    input  wire logic       i_bin_start,
    output logic            o_valid,
    input  wire logic       i_q_ready,
    output t_lgpl_item      o_item
);

    logic signed [15:0] w_cx, w_cy, w_cz;
    logic signed [15:0] w_px, w_py, w_pz;
    logic [34:0]        w_hi;
    logic               w_steep;

    // Stage valids and advance enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    // Previous point.
    logic signed [15:0] r_prev_x, r_prev_y, r_prev_z;

    // Stage 1: magnitudes.
    logic [15:0] r1_adx, r1_ady, r1_adz;
    logic [15:0] r1_acx, r1_acy, r1_acz;
    logic [15:0] r1_apx, r1_apy, r1_apz;
    // Stage 2: squares.
    logic [31:0] r2_dx2, r2_dy2, r2_dz2;
    logic [31:0] r2_cx2, r2_cy2, r2_cz2;
    logic [31:0] r2_px2, r2_py2, r2_pz2;
    // Stage 3: sums.
    logic [33:0] r3_d2;
    logic [31:0] r3_rc, r3_rp, r3_dz2;
    // Stage 4: slope products and range result.
    logic [63:0] r4_lo;
    logic [33:0] r4_hp;
    logic [31:0] r4_dz2;
    logic        r4_zero, r4_grows;
    // Squared slope sine.
    logic [31:0] r_s2;

    // Side fields carried along the pipeline.
    logic signed [15:0] r1_cz, r2_cz, r3_cz, r4_cz;
    logic signed [15:0] r1_pz, r2_pz, r3_pz, r4_pz;
    logic r1_bin, r2_bin, r3_bin, r4_bin;
    logic r1_low, r2_low, r3_low, r4_low;

    assign w_cx = i_data[15:0];
    assign w_cy = i_data[31:16];
    assign w_cz = i_data[47:32];

    // A bin start replaces the previous point by the virtual start point.
    assign w_px = i_bin_start ? 16'sd0 : r_prev_x;
    assign w_py = i_bin_start ? 16'sd0 : r_prev_y;
    assign w_pz = i_bin_start ? i_cfg.sensor_height : r_prev_z;

    // Pipeline advances when the next stage has room.
    assign w_adv4  = !r_v4 || i_q_ready;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_prev_x <= 16'sd0;
            r_prev_y <= 16'sd0;
            r_prev_z <= 16'sd0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
            if (i_valid && w_adv1) begin
                r_prev_x <= w_cx;
                r_prev_y <= w_cy;
                r_prev_z <= w_cz;
            end
        end
    end

    // Squared sine follows the register; it settles while the block is idle.
    always_ff @(posedge i_clk) begin
        r_s2 <= square16(i_cfg.max_slope_sine);
    end

    // Stage 1: differences and magnitudes.
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_adx <= abs_diff(w_cx, w_px);
            r1_ady <= abs_diff(w_cy, w_py);
            r1_adz <= abs_diff(w_cz, w_pz);
            r1_acx <= abs_diff(w_cx, 16'sd0);
            r1_acy <= abs_diff(w_cy, 16'sd0);
            r1_acz <= abs_diff(w_cz, 16'sd0);
            r1_apx <= abs_diff(w_px, 16'sd0);
            r1_apy <= abs_diff(w_py, 16'sd0);
            r1_apz <= abs_diff(w_pz, 16'sd0);
            r1_cz  <= w_cz;
            r1_pz  <= w_pz;
            r1_bin <= i_bin_start;
            r1_low <= w_cz < w_pz;
        end
    end

    // Stage 2: squares.
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_dx2 <= square16(r1_adx);
            r2_dy2 <= square16(r1_ady);
            r2_dz2 <= square16(r1_adz);
            r2_cx2 <= square16(r1_acx);
            r2_cy2 <= square16(r1_acy);
            r2_cz2 <= square16(r1_acz);
            r2_px2 <= square16(r1_apx);
            r2_py2 <= square16(r1_apy);
            r2_pz2 <= square16(r1_apz);
            r2_cz  <= r1_cz;
            r2_pz  <= r1_pz;
            r2_bin <= r1_bin;
            r2_low <= r1_low;
        end
    end

    // Stage 3: squared distance and squared ranges; ranges stay below 2^32.
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r3_d2  <= 34'(r2_dx2) + 34'(r2_dy2) + 34'(r2_dz2);
            r3_rc  <= r2_cx2 + r2_cy2 + r2_cz2;
            r3_rp  <= r2_px2 + r2_py2 + r2_pz2;
            r3_dz2 <= r2_dz2;
            r3_cz  <= r2_cz;
            r3_pz  <= r2_pz;
            r3_bin <= r2_bin;
            r3_low <= r2_low;
        end
    end

    // Stage 4: sine squared times distance squared, split at bit 32.
    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r4_lo    <= {32'b0, r_s2} * {32'b0, r3_d2[31:0]};
            r4_hp    <= {2'b0, r_s2} * {32'b0, r3_d2[33:32]};
            r4_zero  <= r3_d2 == 34'd0;
            r4_grows <= r3_rp < r3_rc;
            r4_dz2   <= r3_dz2;
            r4_cz    <= r3_cz;
            r4_pz    <= r3_pz;
            r4_bin   <= r3_bin;
            r4_low   <= r3_low;
        end
    end

    // Slope compare: dz^2 against the upper part of the product.
    assign w_hi    = 35'(r4_lo[63:32]) + 35'(r4_hp);
    assign w_steep = 35'(r4_dz2) > w_hi;

    assign o_valid          = r_v4;
    assign o_item.hit       = r4_zero || w_steep || !r4_grows;
    assign o_item.lower     = r4_low;
    assign o_item.cur_z     = r4_cz;
    assign o_item.prev_z    = r4_pz;
    assign o_item.bin_start = r4_bin;

endmodule

`default_nettype wire

// ===== rtl/lgpl_queue.sv =====
// ----------------------------------------------------------------------------
// LiDAR ground labeller queue
// Short first-in first-out buffer of classified points between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpl_queue
    import lgpl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_lgpl_item i_item,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_lgpl_item      o_item
);

    t_lgpl_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   w_push, w_pop;

    assign o_ready = r_count != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

`default_nettype wire

// ===== rtl/lgpl_back.sv =====
// ----------------------------------------------------------------------------
// LiDAR ground labeller back
// Two-mode labelling machine with the last ground height, and the output
// register of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpl_back
    import lgpl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_lgpl_cfg  i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_lgpl_item i_item,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_ground
);

    typedef enum logic {
        MODE_GROUND,
        MODE_OBJECT
    } t_mode;

    t_mode              r_mode, n_mode;
    logic signed [15:0] r_lgh, n_lgh;
    logic               r_valid, r_ground, n_ground;
    logic               w_pop, w_in_ground, w_within;
    logic [15:0]        w_gap;

    assign o_ready = !r_valid || i_ready;
    assign w_pop   = i_valid && o_ready;

    // A bin start forces ground mode before the point is judged.
    assign w_in_ground = i_item.bin_start || (r_mode == MODE_GROUND);
    assign w_gap       = abs_diff(r_lgh, i_item.cur_z);
    assign w_within    = w_gap <= {1'b0, i_cfg.max_ground_step};

    // Next mode, label and last ground height.
    always_comb begin
        n_lgh = r_lgh;
        if (w_in_ground) begin
            n_ground = !i_item.hit;
            n_mode   = i_item.hit ? MODE_OBJECT : MODE_GROUND;
            if (i_item.hit) n_lgh = i_item.prev_z;
        end else begin
            n_ground = i_item.lower && w_within;
            n_mode   = n_ground ? MODE_GROUND : MODE_OBJECT;
        end
    end

    // State and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_GROUND;
            r_lgh   <= 16'sd0;
            r_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_mode  <= n_mode;
                r_lgh   <= n_lgh;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) r_ground <= n_ground;
    end

    assign o_valid  = r_valid;
    assign o_ground = r_ground;

endmodule

`default_nettype wire

// ===== rtl/lidar_ground_point_labeler_core.sv =====
// Throughput: one point per cycle while the label stream is not stalled; the
// four-stage front pipeline and the one-bit mode update in the back each take
// a point every cycle. A four-entry queue lets the front run on while the
// output is stalled.
// Reset is synchronous and active low; it restores the register defaults,
// ground mode and a zero previous point, and empties the pipeline at once.
// ----------------------------------------------------------------------------
// LiDAR ground point labeller
// Labels each point of a range-sorted azimuth bin as ground or non-ground
// from its slope and range against the previous point.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_ground_point_labeler_core
    import lgpl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    // Point stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // point_x, point_y, point_z
    input  wire logic        i_s_axis_tuser,  // bin_start
    // Label stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata   // is_ground, zero fill
);

    t_lgpl_cfg  r_cfg;
    t_lgpl_item w_f_item, w_q_item;
    logic       w_f_valid, w_q_ready, w_q_valid, w_b_ready, w_ground;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_height   <= SENSOR_HEIGHT_RST;
            r_cfg.max_slope_sine  <= MAX_SLOPE_SINE_RST;
            r_cfg.max_ground_step <= MAX_GROUND_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SENSOR_HEIGHT:   r_cfg.sensor_height   <= i_cfg_wdata;
                CFG_MAX_SLOPE_SINE:  r_cfg.max_slope_sine  <= i_cfg_wdata;
                CFG_MAX_GROUND_STEP: r_cfg.max_ground_step <= i_cfg_wdata[14:0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    // Front: tests on each point.
    lgpl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_bin_start (i_s_axis_tuser),
        .o_valid     (w_f_valid),
        .i_q_ready   (w_q_ready),
        .o_item      (w_f_item)
    );

    // Queue between front and back.
    lgpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_q_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_b_ready),
        .o_item  (w_q_item)
    );

    // Back: mode machine and output.
    lgpl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_q_valid),
        .o_ready  (w_b_ready),
        .i_item   (w_q_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_ground (w_ground)
    );

    assign o_m_axis_tdata = {7'b0, w_ground};

endmodule

`default_nettype wire

// ===== rtl/lgpl_port_chk.sv =====
// ----------------------------------------------------------------------------
// LiDAR ground labeller port checks
// Watches the top-level ports: reset, output hold, padding and the balance
// of points in and labels out.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpl_port_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata
);

    logic [3:0] r_pending;
    logic       w_in, w_out;

    assign w_in  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out = o_m_axis_tvalid && i_m_axis_tready;

    // Points accepted whose labels are not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({w_in, w_out})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // Reset empties the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("label valid after reset");

    // A stalled label stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("label withdrawn while stalled");

    // No label without an outstanding point.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out |-> (r_pending != 4'd0) || w_in)
        else $error("label without a pending point");

    // Pipeline, queue and output register hold at most nine points.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd9)
        else $error("more points in flight than storage");

    // Padding bits of the label stay zero.
    a_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:1] == 7'd0)
        else $error("label padding not zero");

endmodule

bind lidar_ground_point_labeler_core lgpl_port_chk u_port_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
